FILE: rtl/core/li3d_pkg.sv
package li3d_pkg;

    localparam int COORD_W = 32;
    localparam int CHUNK_W = 32;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        t_coord dir1_x;
        t_coord dir1_y;
        t_coord dir1_z;
        t_coord pt1_x;
        t_coord pt1_y;
        t_coord pt1_z;
        t_coord dir2_x;
        t_coord dir2_y;
        t_coord dir2_z;
        t_coord pt2_x;
        t_coord pt2_y;
        t_coord pt2_z;
    } t_in_item;

    typedef struct packed {
        t_coord hit_x;
        t_coord hit_y;
        t_coord hit_z;
        logic   parallel;
        logic   saturated;
    } t_out_item;

endpackage

FILE: rtl/core/li3d_mul.sv
module li3d_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int CW = li3d_pkg::CHUNK_W;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int PW = AW + BW;
    localparam int XW = 2 * CW + 2;

    logic signed [NA*CW-1:0] ax;
    logic signed [NB*CW-1:0] bx;
    logic signed [CW:0]      ca [NA];
    logic signed [CW:0]      cb [NB];
    logic signed [XW-1:0]    r_pp [NA][NB];
    logic signed [PW-1:0]    n_row [NA];
    logic signed [PW-1:0]    r_row [NA];
    logic signed [PW-1:0]    n_sum;
    logic signed [PW-1:0]    r_prod;

    assign ax = (NA*CW)'(i_a);
    assign bx = (NB*CW)'(i_b);

    // signed top chunk, unsigned lower chunks
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            ca[i] = {(i == NA - 1) ? ax[i*CW+CW-1] : 1'b0, ax[i*CW +: CW]};
        end
        for (int j = 0; j < NB; j++) begin
            cb[j] = {(j == NB - 1) ? bx[j*CW+CW-1] : 1'b0, bx[j*CW +: CW]};
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) <<< (j * CW));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] <<< (i * CW));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= ca[i] * cb[j];
            end
            r_row[i] <= n_row[i];
        end
        r_prod <= n_sum;
    end

    assign o_p = r_prod;

endmodule

FILE: rtl/core/li3d_div.sv
module li3d_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = 33
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    output logic [QB-1:0] o_q,
    output logic          o_ovf
);
    localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [RW-1:0] r_rem [QB+1];
    logic [RW-1:0] r_dv  [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];
    logic [RW-1:0] n_sub [QB];
    logic          n_bit [QB];

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_sub[k] = r_dv[k] << (QB - 1 - k);
            n_bit[k] = (r_rem[k] >= n_sub[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_n);
        r_dv[0]  <= RW'(i_d);
        r_q[0]   <= '0;
        r_ovf[0] <= (RW'(i_n) >= (RW'(i_d) << QB));
        for (int k = 0; k < QB; k++) begin
            r_rem[k+1] <= n_bit[k] ? (r_rem[k] - n_sub[k]) : r_rem[k];
            r_dv[k+1]  <= r_dv[k];
            r_q[k+1]   <= r_q[k] | (QB'(n_bit[k]) << (QB - 1 - k));
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_q   = r_q[QB];
    assign o_ovf = r_ovf[QB];

endmodule

FILE: rtl/core/line_intersection_3d_unit.sv
// a start gives its done strobe once the item has passed three pipelined multiplier stages
//   plus a restoring divider of COORD_W+2 stages
// throughput: one item per cycle, busy stays low, every stage advances each cycle
// reset clears only the valid pipeline; data registers are not reset
module line_intersection_3d_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  li3d_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output li3d_pkg::t_out_item o_result
);
    localparam int W     = li3d_pkg::COORD_W;
    localparam int ML    = 3;
    localparam int QB    = W + 1;
    localparam int DL    = QB + 1;
    localparam int S_DIF = 1;
    localparam int S_X   = S_DIF + ML + 1;
    localparam int S_DOT = S_X + ML + 1;
    localparam int S_MAG = S_DOT + ML + 1;
    localparam int S_DIV = S_MAG + 1;
    localparam int S_DQ  = S_DIV + DL;
    localparam int S_OUT = S_DQ + 1;
    localparam int PD    = S_DQ - S_X;
    localparam int ND    = S_MAG - S_DOT;
    localparam int NG    = S_DQ - S_MAG + 1;

    localparam int VW    = 2 * W + 1;
    localparam int UW    = 2 * W + 2;
    localparam int DENW  = 2 * VW + 2;
    localparam int NUMW  = UW + VW + 2;
    localparam int NW    = NUMW + W;
    localparam int DIVNW = NW + 2;
    localparam int DIVDW = DENW + 1;

    logic [S_OUT:0]      r_vld;
    li3d_pkg::t_in_item  r_ipl [S_DQ+1];

    li3d_pkg::t_coord    p1_in  [3];
    li3d_pkg::t_coord    p2_in  [3];
    li3d_pkg::t_coord    d1_dif [3];
    li3d_pkg::t_coord    d2_dif [3];
    li3d_pkg::t_coord    d1_dot [3];
    li3d_pkg::t_coord    p1_dq  [3];

    logic signed [W:0]        r_diff [3];
    logic signed [2*W-1:0]    w_v4a [3];
    logic signed [2*W-1:0]    w_v4b [3];
    logic signed [2*W:0]      w_v3a [3];
    logic signed [2*W:0]      w_v3b [3];
    logic signed [VW-1:0]     r_v4 [3];
    logic signed [UW-1:0]     r_v3 [3];
    logic signed [2*VW-1:0]   w_sq [3];
    logic signed [UW+VW-1:0]  w_nm [3];
    logic [DENW-1:0]          r_den;
    logic signed [NUMW-1:0]   r_num;
    logic [DENW-1:0]          r_dend [ND];
    logic [PD-1:0]            r_par;
    logic signed [NW-1:0]     w_n [3];
    logic [NG-1:0]            r_neg [3];
    logic [NW-1:0]            r_mag [3];
    logic [DIVNW-1:0]         r_divn [3];
    logic [DIVDW-1:0]         r_divd;
    logic [QB-1:0]            w_q [3];
    logic                     w_ovf [3];
    logic signed [QB:0]       n_qs [3];
    logic signed [W+2:0]      n_r [3];
    li3d_pkg::t_coord         n_hit [3];
    logic                     n_sat;
    li3d_pkg::t_out_item      n_out;
    li3d_pkg::t_out_item      r_out;

    assign busy = 1'b0;

    assign p1_in[0]  = r_ipl[0].pt1_x;
    assign p1_in[1]  = r_ipl[0].pt1_y;
    assign p1_in[2]  = r_ipl[0].pt1_z;
    assign p2_in[0]  = r_ipl[0].pt2_x;
    assign p2_in[1]  = r_ipl[0].pt2_y;
    assign p2_in[2]  = r_ipl[0].pt2_z;
    assign d1_dif[0] = r_ipl[S_DIF].dir1_x;
    assign d1_dif[1] = r_ipl[S_DIF].dir1_y;
    assign d1_dif[2] = r_ipl[S_DIF].dir1_z;
    assign d2_dif[0] = r_ipl[S_DIF].dir2_x;
    assign d2_dif[1] = r_ipl[S_DIF].dir2_y;
    assign d2_dif[2] = r_ipl[S_DIF].dir2_z;
    assign d1_dot[0] = r_ipl[S_DOT].dir1_x;
    assign d1_dot[1] = r_ipl[S_DOT].dir1_y;
    assign d1_dot[2] = r_ipl[S_DOT].dir1_z;
    assign p1_dq[0]  = r_ipl[S_DQ].pt1_x;
    assign p1_dq[1]  = r_ipl[S_DQ].pt1_y;
    assign p1_dq[2]  = r_ipl[S_DQ].pt1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_OUT-1:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ipl[0] <= i_item;
        for (int s = 1; s <= S_DQ; s++) begin
            r_ipl[s] <= r_ipl[s-1];
        end
    end

    // p2 - p1
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_diff[c] <= (W+1)'(p2_in[c]) - (W+1)'(p1_in[c]);
        end
    end

    // v4 = d1 x d2, v3 = (p2 - p1) x d2, then v4.v4 and v3.v4
    for (genvar c = 0; c < 3; c++) begin : g_vec
        li3d_mul #(.AW(W), .BW(W)) u_v4a (
            .i_clk (i_clk),
            .i_a   (d1_dif[(c+1)%3]),
            .i_b   (d2_dif[(c+2)%3]),
            .o_p   (w_v4a[c])
        );
        li3d_mul #(.AW(W), .BW(W)) u_v4b (
            .i_clk (i_clk),
            .i_a   (d1_dif[(c+2)%3]),
            .i_b   (d2_dif[(c+1)%3]),
            .o_p   (w_v4b[c])
        );
        li3d_mul #(.AW(W+1), .BW(W)) u_v3a (
            .i_clk (i_clk),
            .i_a   (r_diff[(c+1)%3]),
            .i_b   (d2_dif[(c+2)%3]),
            .o_p   (w_v3a[c])
        );
        li3d_mul #(.AW(W+1), .BW(W)) u_v3b (
            .i_clk (i_clk),
            .i_a   (r_diff[(c+2)%3]),
            .i_b   (d2_dif[(c+1)%3]),
            .o_p   (w_v3b[c])
        );
        li3d_mul #(.AW(VW), .BW(VW)) u_sq (
            .i_clk (i_clk),
            .i_a   (r_v4[c]),
            .i_b   (r_v4[c]),
            .o_p   (w_sq[c])
        );
        li3d_mul #(.AW(UW), .BW(VW)) u_nm (
            .i_clk (i_clk),
            .i_a   (r_v3[c]),
            .i_b   (r_v4[c]),
            .o_p   (w_nm[c])
        );
        li3d_mul #(.AW(NUMW), .BW(W)) u_n (
            .i_clk (i_clk),
            .i_a   (r_num),
            .i_b   (d1_dot[c]),
            .o_p   (w_n[c])
        );
        li3d_div #(.NW(DIVNW), .DW(DIVDW), .QB(QB)) u_div (
            .i_clk (i_clk),
            .i_n   (r_divn[c]),
            .i_d   (r_divd),
            .o_q   (w_q[c]),
            .o_ovf (w_ovf[c])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_v4[c] <= VW'(w_v4a[c]) - VW'(w_v4b[c]);
            r_v3[c] <= UW'(w_v3a[c]) - UW'(w_v3b[c]);
        end
        r_den <= DENW'(w_sq[0]) + DENW'(w_sq[1]) + DENW'(w_sq[2]);
        r_num <= NUMW'(w_nm[0]) + NUMW'(w_nm[1]) + NUMW'(w_nm[2]);
        r_dend[0] <= r_den;
        for (int s = 1; s < ND; s++) begin
            r_dend[s] <= r_dend[s-1];
        end
        r_par <= {r_par[PD-2:0],
                  (r_v4[0] == '0) && (r_v4[1] == '0) && (r_v4[2] == '0)};
        for (int c = 0; c < 3; c++) begin
            r_neg[c]  <= {r_neg[c][NG-2:0], w_n[c][NW-1]};
            r_mag[c]  <= w_n[c][NW-1] ? NW'(-w_n[c]) : NW'(w_n[c]);
            r_divn[c] <= (DIVNW'(r_mag[c]) << 1) + DIVNW'(r_dend[ND-1]);
        end
        r_divd <= DIVDW'(r_dend[ND-1]) << 1;
    end

    // sign, offset by p1, clip
    always_comb begin
        n_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_qs[c] = $signed({1'b0, w_q[c]});
            if (r_neg[c][NG-1]) begin
                n_qs[c] = -n_qs[c];
            end
            n_r[c] = (W+3)'(p1_dq[c]) + (W+3)'(n_qs[c]);
            if (w_ovf[c]) begin
                n_hit[c] = r_neg[c][NG-1] ? li3d_pkg::COORD_MIN : li3d_pkg::COORD_MAX;
                n_sat = 1'b1;
            end else if (n_r[c] > (W+3)'(li3d_pkg::COORD_MAX)) begin
                n_hit[c] = li3d_pkg::COORD_MAX;
                n_sat = 1'b1;
            end else if (n_r[c] < (W+3)'(li3d_pkg::COORD_MIN)) begin
                n_hit[c] = li3d_pkg::COORD_MIN;
                n_sat = 1'b1;
            end else begin
                n_hit[c] = n_r[c][W-1:0];
            end
        end
        if (r_par[PD-1]) begin
            n_out.hit_x     = '0;
            n_out.hit_y     = '0;
            n_out.hit_z     = '0;
            n_out.parallel  = 1'b1;
            n_out.saturated = 1'b0;
        end else begin
            n_out.hit_x     = n_hit[0];
            n_out.hit_y     = n_hit[1];
            n_out.hit_z     = n_hit[2];
            n_out.parallel  = 1'b0;
            n_out.saturated = n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done   = r_vld[S_OUT];
    assign o_result = r_out;

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.parallel |-> (o_result.hit_x == '0) && (o_result.hit_y == '0)
            && (o_result.hit_z == '0) && !o_result.saturated)
        else $error("parallel item with nonzero point");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(S_OUT + 1) o_done)
        else $error("item lost in pipeline");

    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, S_OUT + 1))
        else $error("result without item");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

typedef logic signed [319:0] t_wide;

class isect_scoreboard;
    li3d_pkg::t_out_item expected_q[$];
    int                  errors;

    function new();
        errors = 0;
    endfunction

    function li3d_pkg::t_out_item predict_hit(li3d_pkg::t_in_item it);
        t_wide               d1[3], p1[3], d2[3], p2[3], df[3], v3[3], v4[3];
        t_wide               num, den, n, mag, q, r, hi, lo;
        li3d_pkg::t_out_item res;
        logic                sat;
        d1[0] = it.dir1_x; d1[1] = it.dir1_y; d1[2] = it.dir1_z;
        p1[0] = it.pt1_x;  p1[1] = it.pt1_y;  p1[2] = it.pt1_z;
        d2[0] = it.dir2_x; d2[1] = it.dir2_y; d2[2] = it.dir2_z;
        p2[0] = it.pt2_x;  p2[1] = it.pt2_y;  p2[2] = it.pt2_z;
        for (int k = 0; k < 3; k++) df[k] = p2[k] - p1[k];
        v3[0] = df[1] * d2[2] - df[2] * d2[1];
        v3[1] = df[2] * d2[0] - df[0] * d2[2];
        v3[2] = df[0] * d2[1] - df[1] * d2[0];
        v4[0] = d1[1] * d2[2] - d1[2] * d2[1];
        v4[1] = d1[2] * d2[0] - d1[0] * d2[2];
        v4[2] = d1[0] * d2[1] - d1[1] * d2[0];
        den = v4[0] * v4[0] + v4[1] * v4[1] + v4[2] * v4[2];
        res = '0;
        if (den == 0) begin
            res.parallel = 1'b1;
            return res;
        end
        num = v3[0] * v4[0] + v3[1] * v4[1] + v3[2] * v4[2];
        hi  = li3d_pkg::COORD_MAX;
        lo  = li3d_pkg::COORD_MIN;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n   = num * d1[k];
            mag = (n < 0) ? -n : n;
            q   = (2 * mag + den) / (2 * den);
            if (n < 0) q = -q;
            r = p1[k] + q;
            if (r > hi) begin
                r   = hi;
                sat = 1'b1;
            end else if (r < lo) begin
                r   = lo;
                sat = 1'b1;
            end
            case (k)
                0: res.hit_x = r[31:0];
                1: res.hit_y = r[31:0];
                default: res.hit_z = r[31:0];
            endcase
        end
        res.saturated = sat;
        return res;
    endfunction

    function void note_item(li3d_pkg::t_in_item it);
        expected_q.push_back(predict_hit(it));
    endfunction

    function void check_result(li3d_pkg::t_out_item got);
        li3d_pkg::t_out_item exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %p actual %p", exp_r, got);
        end
    endfunction
endclass

module tb_top;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM   = 1200;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    li3d_pkg::t_in_item  i_item;
    logic                busy;
    logic                o_done;
    li3d_pkg::t_out_item o_result;

    isect_scoreboard sb;
    int idle_cycles;
    int burst_left;

    line_intersection_3d_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(i_item);
            if (o_done) sb.check_result(o_result);
            if ((start && !busy) || o_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic li3d_pkg::t_coord rnd_bits(int bits);
        li3d_pkg::t_coord v;
        v = $urandom;
        v = v <<< (32 - bits);
        return v >>> (32 - bits);
    endfunction

    function automatic li3d_pkg::t_coord any_coord();
        case ($urandom_range(0, 5))
            0: return li3d_pkg::COORD_MAX;
            1: return li3d_pkg::COORD_MIN;
            2: return '0;
            default: return li3d_pkg::t_coord'($urandom);
        endcase
    endfunction

    task automatic send_item(li3d_pkg::t_in_item it);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic li3d_pkg::t_in_item make_crossing(int pbits, int dbits);
        li3d_pkg::t_in_item it;
        li3d_pkg::t_coord   px, py, pz;
        int                 a, b;
        px = rnd_bits(pbits); py = rnd_bits(pbits); pz = rnd_bits(pbits);
        it.dir1_x = rnd_bits(dbits); it.dir1_y = rnd_bits(dbits); it.dir1_z = rnd_bits(dbits);
        it.dir2_x = rnd_bits(dbits); it.dir2_y = rnd_bits(dbits); it.dir2_z = rnd_bits(dbits);
        a = $urandom_range(0, 16) - 8;
        b = $urandom_range(0, 16) - 8;
        it.pt1_x = px - a * it.dir1_x; it.pt1_y = py - a * it.dir1_y;
        it.pt1_z = pz - a * it.dir1_z;
        it.pt2_x = px - b * it.dir2_x; it.pt2_y = py - b * it.dir2_y;
        it.pt2_z = pz - b * it.dir2_z;
        if ($urandom_range(0, 3) == 0) it.pt2_z = it.pt2_z + rnd_bits(12);
        return it;
    endfunction

    task automatic run_directed();
        li3d_pkg::t_in_item it;
        it = '0;
        send_item(it);
        it = {12{li3d_pkg::COORD_MAX}};
        send_item(it);
        it = {12{li3d_pkg::COORD_MIN}};
        send_item(it);
        it = '0;
        it.dir1_x = 32'sh0001_0000; it.dir2_y = 32'sh0001_0000;
        it.pt2_x = 32'sh0003_0000; it.pt2_z = 32'sh0002_0000;
        send_item(it);
        it.dir2_x = 32'sh0002_0000; it.dir2_y = '0;
        send_item(it);
        it.dir1_x = '0;
        send_item(it);
        it = '0;
        it.dir1_x = li3d_pkg::COORD_MAX; it.dir2_y = 32'sh0000_0001;
        it.pt1_x = li3d_pkg::COORD_MAX; it.pt2_x = li3d_pkg::COORD_MIN;
        send_item(it);
        it.pt1_x = li3d_pkg::COORD_MIN; it.pt2_x = li3d_pkg::COORD_MAX;
        send_item(it);
        it = '0;
        it.dir1_x = 32'sh2; it.dir2_y = 32'sh1; it.pt2_x = 32'sh1;
        send_item(it);
        it.dir1_x = -32'sh2; it.pt2_x = -32'sh1;
        send_item(it);
        it = '0;
        it.dir1_x = li3d_pkg::COORD_MIN; it.dir1_y = li3d_pkg::COORD_MAX;
        it.dir1_z = li3d_pkg::COORD_MIN;
        it.dir2_x = li3d_pkg::COORD_MAX; it.dir2_y = li3d_pkg::COORD_MIN;
        it.dir2_z = 32'sh1;
        it.pt1_x = li3d_pkg::COORD_MAX; it.pt2_y = li3d_pkg::COORD_MIN;
        it.pt2_z = li3d_pkg::COORD_MAX;
        send_item(it);
        for (int i = 0; i < 6; i++) send_item(make_crossing(20, 18));
    endtask

    initial begin
        li3d_pkg::t_in_item it;
        sb          = new();
        idle_cycles = 0;
        burst_left  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        run_directed();
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int b = 0; b < 12; b++) it[b*32 +: 32] = $urandom;
                end
                2: begin
                    it.dir1_x = any_coord(); it.dir1_y = any_coord();
                    it.dir1_z = any_coord(); it.pt1_x = any_coord();
                    it.pt1_y = any_coord(); it.pt1_z = any_coord();
                    it.dir2_x = any_coord(); it.dir2_y = any_coord();
                    it.dir2_z = any_coord(); it.pt2_x = any_coord();
                    it.pt2_y = any_coord(); it.pt2_z = any_coord();
                end
                3: begin
                    int s;
                    it = make_crossing(24, 14);
                    s = $urandom_range(0, 6) - 3;
                    it.dir2_x = s * it.dir1_x; it.dir2_y = s * it.dir1_y;
                    it.dir2_z = s * it.dir1_z;
                end
                4: it = make_crossing(31, 28);
                default: it = make_crossing($urandom_range(8, 26), $urandom_range(4, 20));
            endcase
            send_item(it);
            if (i == N_RANDOM / 2) begin
                while (sb.expected_q.size() != 0) @(negedge i_clk);
            end
        end
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0 && !o_done)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/li3d_pkg.sv
rtl/core/li3d_mul.sv
rtl/core/li3d_div.sv
rtl/core/line_intersection_3d_unit.sv
tb/sv/tb_top.sv
